// File: rtl/vbam_pkg.sv
// ----------------------------------------------------------------------------
// vbam_pkg
// Shared types, constants and helpers of the video bus address map.
// ----------------------------------------------------------------------------
package vbam_pkg;

  localparam int unsigned ADDR_W      = 14;
  localparam int unsigned DATA_W      = 8;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned PAL_IDX_W   = 5;
  localparam int unsigned PAL_DEPTH   = 28;
  localparam int unsigned PATTERN_HALF_BYTES_DEF = 4096;
  localparam int unsigned WINDOW_BYTES_DEF       = 1024;

  // Address bits 13:8 all set select the palette
  localparam logic [5:0] PAL_PAGE_HI = 6'h3F;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    MIR_VERTICAL   = 2'd0,
    MIR_HORIZONTAL = 2'd1,
    MIR_ONE_SCREEN = 2'd2,
    MIR_FOUR       = 2'd3
  } mirror_e;

  typedef enum logic [1:0] {
    TGT_PATTERN   = 2'd0,
    TGT_NAMETABLE = 2'd1,
    TGT_PALETTE   = 2'd2
  } target_e;

  typedef struct packed {
    target_e tgt;
    logic    rd;
    logic    wr;
  } access_t;

  // Fold the 32 palette addresses onto 28 stored bytes
  function automatic logic [PAL_IDX_W-1:0] pal_slot(input logic [PAL_IDX_W-1:0] idx);
    logic [PAL_IDX_W-1:0] slot;
    if (!idx[4]) begin
      slot = idx;
    end else if (idx[1:0] == 2'd0) begin
      slot = {1'b0, idx[3:0]};
    end else begin
      slot = PAL_IDX_W'(16) + PAL_IDX_W'(idx[3:2]) * PAL_IDX_W'(3)
           + PAL_IDX_W'(idx[1:0]) - PAL_IDX_W'(1);
    end
    return slot;
  endfunction

  function automatic logic [DATA_W-1:0] pal_reset(input int unsigned i);
    logic [DATA_W-1:0] v;
    case (i)
      0:       v = 8'h0d;
      1:       v = 8'h02;
      2:       v = 8'h06;
      3:       v = 8'h0a;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/vbam_if.sv
// ----------------------------------------------------------------------------
// vbam_req_if / vbam_rsp_if
// Valid/ready channels for bus accesses and read results.
// ----------------------------------------------------------------------------
interface vbam_req_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [vbam_pkg::ADDR_W-1:0] address;
  logic [vbam_pkg::DATA_W-1:0] write_data;

  modport source (output valid, output operation, output address, output write_data,
                  input ready);
  modport sink   (input valid, input operation, input address, input write_data,
                  output ready);
endinterface

interface vbam_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [vbam_pkg::DATA_W-1:0] read_data;

  modport source (output valid, output read_data, input ready);
  modport sink   (input valid, input read_data, output ready);
endinterface

// File: rtl/vbam_decode.sv
// ----------------------------------------------------------------------------
// vbam_decode
// Maps a bus address onto pattern, name-table or palette storage.
// ----------------------------------------------------------------------------
module vbam_decode #(
  parameter int unsigned PAT_AW = 13,
  parameter int unsigned WIN_AW = 10
) (
  input  logic                           valid_i,
  input  logic                           operation_i,
  input  logic [vbam_pkg::ADDR_W-1:0]    address_i,
  input  logic [vbam_pkg::MODE_W-1:0]    mode_i,
  output vbam_pkg::access_t              acc_o,
  output logic [PAT_AW-1:0]              pat_idx_o,
  output logic [WIN_AW+1:0]              nt_idx_o,
  output logic [vbam_pkg::PAL_IDX_W-1:0] pal_idx_o
);

  logic [1:0] window;
  logic [1:0] page;

  assign window = address_i[WIN_AW+1:WIN_AW];

  always_comb begin
    case (vbam_pkg::mirror_e'(mode_i))
      vbam_pkg::MIR_VERTICAL:   page = {1'b0, window[0]};
      vbam_pkg::MIR_HORIZONTAL: page = {1'b0, window[1]};
      vbam_pkg::MIR_ONE_SCREEN: page = 2'd0;
      vbam_pkg::MIR_FOUR:       page = window;
      default:                  page = window;
    endcase
  end

  always_comb begin
    if (!address_i[13]) begin
      acc_o.tgt = vbam_pkg::TGT_PATTERN;
    end else if (address_i[13:8] == vbam_pkg::PAL_PAGE_HI) begin
      acc_o.tgt = vbam_pkg::TGT_PALETTE;
    end else begin
      acc_o.tgt = vbam_pkg::TGT_NAMETABLE;
    end
    acc_o.rd = valid_i && (vbam_pkg::op_e'(operation_i) == vbam_pkg::OP_READ);
    acc_o.wr = valid_i && (vbam_pkg::op_e'(operation_i) == vbam_pkg::OP_WRITE);
  end

  assign pat_idx_o = address_i[PAT_AW-1:0];
  assign nt_idx_o  = {page, address_i[WIN_AW-1:0]};
  assign pal_idx_o = vbam_pkg::pal_slot(address_i[vbam_pkg::PAL_IDX_W-1:0]);

endmodule

// File: rtl/vbam_store.sv
// ----------------------------------------------------------------------------
// vbam_store
// Pattern and name-table RAMs plus the palette registers, registered reads.
// ----------------------------------------------------------------------------
module vbam_store #(
  parameter int unsigned PAT_AW = 13,
  parameter int unsigned WIN_AW = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  vbam_pkg::access_t              acc_i,
  input  logic [PAT_AW-1:0]              pat_idx_i,
  input  logic [WIN_AW+1:0]              nt_idx_i,
  input  logic [vbam_pkg::PAL_IDX_W-1:0] pal_idx_i,
  input  logic [vbam_pkg::DATA_W-1:0]    wdata_i,
  output logic [vbam_pkg::DATA_W-1:0]    rdata_o
);

  localparam int unsigned PAT_DEPTH = 1 << PAT_AW;
  localparam int unsigned NT_DEPTH  = 1 << (WIN_AW + 2);

  logic [vbam_pkg::DATA_W-1:0] pat_mem [PAT_DEPTH];
  logic [vbam_pkg::DATA_W-1:0] nt_mem  [NT_DEPTH];
  logic [vbam_pkg::DATA_W-1:0] pal_q   [vbam_pkg::PAL_DEPTH];

  logic [vbam_pkg::DATA_W-1:0] pat_rd_q;
  logic [vbam_pkg::DATA_W-1:0] nt_rd_q;
  logic [vbam_pkg::DATA_W-1:0] pal_rd_q;
  vbam_pkg::target_e           sel_q;

  logic pat_sel;
  logic nt_sel;
  logic pal_sel;

  assign pat_sel = (acc_i.tgt == vbam_pkg::TGT_PATTERN);
  assign nt_sel  = (acc_i.tgt == vbam_pkg::TGT_NAMETABLE);
  assign pal_sel = (acc_i.tgt == vbam_pkg::TGT_PALETTE);

  always_ff @(posedge clk_i) begin
    if (acc_i.wr && pat_sel) begin
      pat_mem[pat_idx_i] <= wdata_i;
    end
    if (acc_i.rd && pat_sel) begin
      pat_rd_q <= pat_mem[pat_idx_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i.wr && nt_sel) begin
      nt_mem[nt_idx_i] <= wdata_i;
    end
    if (acc_i.rd && nt_sel) begin
      nt_rd_q <= nt_mem[nt_idx_i];
    end
  end

  // Palette holds reset colours, so it lives in flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < vbam_pkg::PAL_DEPTH; i++) begin
        pal_q[i] <= vbam_pkg::pal_reset(i);
      end
    end else if (acc_i.wr && pal_sel) begin
      pal_q[pal_idx_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i.rd && pal_sel) begin
      pal_rd_q <= pal_q[pal_idx_i];
    end
  end

  // Remember which store the last read went to
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= vbam_pkg::TGT_PATTERN;
    end else if (acc_i.rd) begin
      sel_q <= acc_i.tgt;
    end
  end

  always_comb begin
    case (sel_q)
      vbam_pkg::TGT_PATTERN:   rdata_o = pat_rd_q;
      vbam_pkg::TGT_NAMETABLE: rdata_o = nt_rd_q;
      vbam_pkg::TGT_PALETTE:   rdata_o = pal_rd_q;
      default:                 rdata_o = pal_rd_q;
    endcase
  end

endmodule

// File: rtl/video_bus_address_map_mirroring.sv
// ----------------------------------------------------------------------------
// video_bus_address_map_mirroring
// Video bus memory map with name-table mirroring and a folded palette.
// ----------------------------------------------------------------------------
// One access is taken per cycle. A read goes through the registered read of the
// pattern and name-table RAMs and palette, then the output register, before its
// byte is presented on rsp; writes produce no result. Input stalls only while a
// read result is waiting on the RAM output and the output register is held by
// the consumer. Mirroring mode is written through cfg_we_i/cfg_wdata_i; the user
// must write it only while the bus is idle, which the block does not enforce.
// Name-table contents survive a mode change. The palette resets to its default
// colours; pattern and name-table bytes are undefined until written.
module video_bus_address_map_mirroring #(
  parameter int unsigned PATTERN_HALF_BYTES = vbam_pkg::PATTERN_HALF_BYTES_DEF,
  parameter int unsigned WINDOW_BYTES       = vbam_pkg::WINDOW_BYTES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [vbam_pkg::MODE_W-1:0] cfg_wdata_i,
  vbam_req_if.sink                    req,
  vbam_rsp_if.source                  rsp
);

  localparam int unsigned PAT_AW = $clog2(2 * PATTERN_HALF_BYTES);
  localparam int unsigned WIN_AW = $clog2(WINDOW_BYTES);

  logic [vbam_pkg::MODE_W-1:0]    mode_q;
  logic                           pend_q;
  logic                           pend_d;
  logic                           out_valid_q;
  logic                           out_valid_d;
  logic [vbam_pkg::DATA_W-1:0]    out_data_q;

  logic                           accept;
  logic                           move;
  vbam_pkg::access_t              acc;
  logic [PAT_AW-1:0]              pat_idx;
  logic [WIN_AW+1:0]              nt_idx;
  logic [vbam_pkg::PAL_IDX_W-1:0] pal_idx;
  logic [vbam_pkg::DATA_W-1:0]    rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= vbam_pkg::MIR_VERTICAL;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // Hold input while the RAM output carries an undelivered byte and the output register is held by the consumer
  assign req.ready = !(pend_q && out_valid_q && !rsp.ready);
  assign accept    = req.valid && req.ready;
  assign move      = pend_q && (!out_valid_q || rsp.ready);

  vbam_decode #(
    .PAT_AW (PAT_AW),
    .WIN_AW (WIN_AW)
  ) u_decode (
    .valid_i     (accept),
    .operation_i (req.operation),
    .address_i   (req.address),
    .mode_i      (mode_q),
    .acc_o       (acc),
    .pat_idx_o   (pat_idx),
    .nt_idx_o    (nt_idx),
    .pal_idx_o   (pal_idx)
  );

  vbam_store #(
    .PAT_AW (PAT_AW),
    .WIN_AW (WIN_AW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .pat_idx_i (pat_idx),
    .nt_idx_i  (nt_idx),
    .pal_idx_i (pal_idx),
    .wdata_i   (req.write_data),
    .rdata_o   (rdata)
  );

  always_comb begin
    pend_d = acc.rd || (pend_q && !move);
    if (move) begin
      out_valid_d = 1'b1;
    end else if (rsp.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_data_q <= rdata;
    end
  end

  assign rsp.valid     = out_valid_q;
  assign rsp.read_data = out_data_q;

endmodule
